// ----- rtl/core/ctwa_pkg.sv -----
// ----------------------------------------------------------------------------
// Client table package
// Sizes, command and status codes, and the record layouts shared by the
// client table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ctwa_pkg;

	localparam int TABLE_SLOTS   = 16;
	localparam int HISTORY_DEPTH = 16;

	localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
	localparam int POS_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
	localparam int CELLS  = TABLE_SLOTS * HISTORY_DEPTH;
	localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;

	localparam int MS_PER_S      = 1000;
	localparam int TIMEOUT_RESET = 600;

	// floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for every 32-bit x.
	localparam logic [28:0] RECIP_1000  = 29'd274877907;
	localparam int          RECIP_SHIFT = 38;

	typedef enum logic [1:0] {
		CMD_UPDATE = 2'd0,
		CMD_SWEEP  = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_UPDATED   = 3'd0,
		STAT_INSERTED  = 3'd1,
		STAT_FULL      = 3'd2,
		STAT_NOT_FOUND = 3'd3,
		STAT_FOUND     = 3'd4,
		STAT_SWEEP     = 3'd5
	} status_t;

	// Per-client record, one memory word per table slot.
	typedef struct packed {
		logic [31:0]        last_ms;
		logic signed [8:0]  rssi;
		logic signed [7:0]  snr;
		logic [7:0]         batt;
		logic               pwr;
		logic [31:0]        pkts;
		logic [POS_W-1:0]   wpos;
		logic [FILL_W-1:0]  fill;
	} rec_t;

	// One history ring record.
	typedef struct packed {
		logic [22:0]        secs;
		logic [7:0]         batt;
		logic signed [8:0]  rssi;
		logic               chg;
	} hist_t;

	// Input word, first field in the lowest bits.
	typedef struct packed {
		logic [1:0]         pad;
		logic [3:0]         hpos;
		logic [31:0]        time_ms;
		logic signed [7:0]  snr;
		logic signed [8:0]  rssi;
		logic               pwr;
		logic [7:0]         batt;
		logic [7:0]         id;
	} in_word_t;

	// Result word, first field in the lowest bits.
	typedef struct packed {
		logic [2:0]         pad;
		logic [22:0]        secs;
		logic [4:0]         evicted;
		logic [4:0]         fill;
		logic [31:0]        pkts;
		logic               pwr;
		logic [7:0]         batt;
		logic signed [7:0]  snr;
		logic signed [8:0]  rssi;
		logic               timed_out;
		logic [4:0]         active;
		logic [3:0]         slot;
	} out_word_t;

endpackage

`default_nettype wire

// ----- rtl/core/ctwa_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ctwa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/ctwa_sec_div.sv -----
// ----------------------------------------------------------------------------
// Millisecond to second divider
// Registered division by 1000 through a reciprocal multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module ctwa_sec_div
	import ctwa_pkg::*;
(
	input  wire logic        clk,
	input  wire logic [31:0] ms,
	output logic      [22:0] secs
);

	logic [60:0] prod;

	assign prod = ms * RECIP_1000;

	always_ff @(posedge clk) begin
		secs <= prod[RECIP_SHIFT+22:RECIP_SHIFT];
	end

endmodule

`default_nettype wire

// ----- rtl/core/client_table_with_aging.sv -----
// ----------------------------------------------------------------------------
// Client table with aging
// Table of radio clients keyed by id, with per-client history rings and a
// timeout sweep.
// ----------------------------------------------------------------------------
// The block takes one command word at a time. Update, query and history read
// pass in order through accept, lookup with record read, fetch with history
// read and divide, and result; the record memory's registered read and the
// divide-by-1000 register set these steps apart. A sweep reads every table
// slot from the record memory, one per cycle. A result waits in the output
// register until taken; the next word is accepted as soon as the sequencer
// is back at idle. Ids and valid bits live in flip-flops and are matched in
// parallel, while the per-slot record and the history rings live in
// memories. History cells that were never written read as zero: a ring is
// filled in order from position zero, so a position at or beyond the slot's
// fill count is known to be unwritten. There is no clearing pass after
// reset. The timeout register is held as a millisecond threshold, so that
// aging needs no divider.
// ----------------------------------------------------------------------------
`default_nettype none

module client_table_with_aging
	import ctwa_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Configuration: timeout_seconds.
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [15:0]  cfg_data,
	// Input words.
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// client_id, battery, power_state, rssi, snr, time_ms, history_pos
	input  wire logic [71:0]  s_axis_tdata,
	// command
	input  wire logic [1:0]   s_axis_tuser,
	// Result words.
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// slot, active_count, timed_out, out_rssi, out_snr, out_battery,
	// out_power, packet_count, history_fill, evicted_count, time_seconds
	output logic [103:0]      m_axis_tdata,
	// status
	output logic [2:0]        m_axis_tuser
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_FETCH,
		ST_DONE,
		ST_SWEEP
	} state_t;

	state_t state_q;

	in_word_t  in_q;
	cmd_t      cmd_q;
	out_word_t out_q;
	logic      out_valid_q;

	logic [31:0] thr_q;

	logic [TABLE_SLOTS-1:0] valid_q;
	logic [TABLE_SLOTS-1:0] written_q;
	logic [7:0]             ids_q [TABLE_SLOTS];
	logic [CNT_W-1:0]       act_q;

	logic [SLOT_W-1:0] slot_q;
	logic              hit_q;
	logic              full_q;
	rec_t              rec_q;
	logic              hv_q;

	logic [CNT_W-1:0]  idx_q;
	logic              pend_s1;
	logic [SLOT_W-1:0] pidx_s1;
	logic [4:0]        ev_q;

	// The configuration write is always taken.
	assign cfg_ready = 1'b1;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	// Status travels beside the data word.
	status_t stat_q;
	assign m_axis_tuser = stat_q;

	logic commit;
	assign commit = !out_valid_q || m_axis_tready;

	// Parallel id match and first free slot.
	logic [SLOT_W-1:0] match_idx, free_idx;
	logic              match_any, free_any;

	always_comb begin
		match_idx = '0;
		match_any = 1'b0;
		free_idx  = '0;
		free_any  = 1'b0;
		for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
			if (valid_q[i] && ids_q[i] == in_q.id) begin
				match_idx = SLOT_W'(i);
				match_any = 1'b1;
			end
			if (!valid_q[i]) begin
				free_idx = SLOT_W'(i);
				free_any = 1'b1;
			end
		end
	end

	logic [SLOT_W-1:0] look_slot;
	assign look_slot = (match_any || cmd_q != CMD_UPDATE) ? match_idx : free_idx;

	// Record memory.
	logic              rec_we, rec_re;
	logic [SLOT_W-1:0] rec_raddr;
	rec_t              rec_rd, rec_new;

	assign rec_re    = (state_q == ST_LOOK) ||
	                   (state_q == ST_SWEEP && idx_q < CNT_W'(TABLE_SLOTS));
	assign rec_raddr = (state_q == ST_LOOK) ? look_slot : idx_q[SLOT_W-1:0];
	assign rec_we    = (state_q == ST_DONE) && commit && cmd_q == CMD_UPDATE && !full_q;

	ctwa_ram #(
		.WIDTH($bits(rec_t)),
		.DEPTH(TABLE_SLOTS)
	) u_rec_ram (
		.clk  (clk),
		.we   (rec_we),
		.waddr(slot_q),
		.wdata(rec_new),
		.re   (rec_re),
		.raddr(rec_raddr),
		.rdata(rec_rd)
	);

	// A slot that was never written reads as the all-zero reset record.
	rec_t rec_fetch;
	assign rec_fetch = written_q[slot_q] ? rec_rd : '0;

	// Updated record for an accepted update.
	always_comb begin
		rec_new         = rec_q;
		rec_new.last_ms = in_q.time_ms;
		rec_new.rssi    = in_q.rssi;
		rec_new.snr     = in_q.snr;
		rec_new.batt    = in_q.batt;
		rec_new.pwr     = in_q.pwr;
		rec_new.pkts    = rec_q.pkts + 32'd1;
		rec_new.wpos    = (rec_q.wpos == POS_W'(HISTORY_DEPTH - 1)) ? '0 :
		                  POS_W'(rec_q.wpos + POS_W'(1));
		if (rec_q.fill < FILL_W'(HISTORY_DEPTH)) begin
			rec_new.fill = FILL_W'(rec_q.fill + FILL_W'(1));
		end
	end

	// Seconds divider: the update time or the stored last-seen time.
	logic [22:0] secs;

	ctwa_sec_div u_sec_div (
		.clk (clk),
		.ms  ((cmd_q == CMD_UPDATE) ? in_q.time_ms : rec_fetch.last_ms),
		.secs(secs)
	);

	// History memory.
	logic [POS_W-1:0]  hpos_mod;
	logic              hist_we, hist_re;
	logic [CELL_W-1:0] hist_waddr, hist_raddr;
	hist_t             hist_wr, hist_rd, hist_out;

	assign hpos_mod   = POS_W'(in_q.hpos % HISTORY_DEPTH);
	assign hist_re    = (state_q == ST_FETCH) && cmd_q == CMD_READ;
	assign hist_raddr = CELL_W'(CELL_W'(slot_q) * CELL_W'(HISTORY_DEPTH) + CELL_W'(hpos_mod));
	assign hist_we    = rec_we;
	assign hist_waddr = CELL_W'(CELL_W'(slot_q) * CELL_W'(HISTORY_DEPTH) + CELL_W'(rec_q.wpos));

	always_comb begin
		hist_wr.secs = secs;
		hist_wr.batt = in_q.batt;
		hist_wr.rssi = in_q.rssi;
		hist_wr.chg  = in_q.pwr;
	end

	ctwa_ram #(
		.WIDTH($bits(hist_t)),
		.DEPTH(CELLS)
	) u_hist_ram (
		.clk  (clk),
		.we   (hist_we),
		.waddr(hist_waddr),
		.wdata(hist_wr),
		.re   (hist_re),
		.raddr(hist_raddr),
		.rdata(hist_rd)
	);

	assign hist_out = hv_q ? hist_rd : '0;

	// Aging: whole seconds above the timeout is the same as the millisecond
	// age reaching (timeout + 1) * 1000.
	logic expired_q;
	assign expired_q = (in_q.time_ms - rec_q.last_ms) >= thr_q;

	logic [31:0] sweep_ls;
	logic        sweep_exp;
	assign sweep_ls  = written_q[pidx_s1] ? rec_rd.last_ms : 32'd0;
	assign sweep_exp = (in_q.time_ms - sweep_ls) >= thr_q;

	// Result word for the command in flight.
	out_word_t res;
	status_t   res_stat;
	logic      ins;

	assign ins = (cmd_q == CMD_UPDATE) && !full_q && !hit_q;

	always_comb begin
		res        = '0;
		res_stat   = STAT_SWEEP;
		res.active = 5'(act_q + CNT_W'(ins));
		unique case (cmd_q)
			CMD_UPDATE: begin
				if (full_q) begin
					res_stat = STAT_FULL;
				end else begin
					res_stat = hit_q ? STAT_UPDATED : STAT_INSERTED;
					res.slot = 4'(slot_q);
					res.rssi = rec_new.rssi;
					res.snr  = rec_new.snr;
					res.batt = rec_new.batt;
					res.pwr  = rec_new.pwr;
					res.pkts = rec_new.pkts;
					res.fill = 5'(rec_new.fill);
					res.secs = secs;
				end
			end
			CMD_SWEEP: begin
				res_stat    = STAT_SWEEP;
				res.evicted = ev_q;
			end
			CMD_QUERY, CMD_READ: begin
				if (!hit_q) begin
					res_stat      = STAT_NOT_FOUND;
					res.timed_out = (cmd_q == CMD_QUERY);
				end else begin
					res_stat = STAT_FOUND;
					res.slot = 4'(slot_q);
					res.rssi = rec_q.rssi;
					res.snr  = rec_q.snr;
					res.batt = rec_q.batt;
					res.pwr  = rec_q.pwr;
					res.pkts = rec_q.pkts;
					res.fill = 5'(rec_q.fill);
					res.secs = secs;
					if (cmd_q == CMD_QUERY) begin
						res.timed_out = expired_q;
					end else begin
						res.rssi = hist_out.rssi;
						res.snr  = '0;
						res.batt = hist_out.batt;
						res.pwr  = hist_out.chg;
						res.secs = hist_out.secs;
					end
				end
			end
			default: begin
				res_stat = STAT_SWEEP;
			end
		endcase
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			in_q  <= s_axis_tdata;
			cmd_q <= cmd_t'(s_axis_tuser);
		end
		if (state_q == ST_LOOK) begin
			slot_q <= look_slot;
			hit_q  <= match_any;
			full_q <= !match_any && !free_any;
		end
		if (state_q == ST_FETCH) begin
			rec_q <= rec_fetch;
			hv_q  <= FILL_W'(hpos_mod) < rec_fetch.fill;
		end
		if (state_q == ST_DONE && commit) begin
			out_q  <= res;
			stat_q <= res_stat;
		end
		// A full table leaves every stored id untouched.
		if (state_q == ST_LOOK && cmd_q == CMD_UPDATE && (match_any || free_any)) begin
			ids_q[look_slot] <= in_q.id;
		end
		if (state_q == ST_SWEEP) begin
			pidx_s1 <= idx_q[SLOT_W-1:0];
		end
	end

	// Sequencer, valid bits and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			thr_q       <= 32'((TIMEOUT_RESET + 1) * MS_PER_S);
			valid_q     <= '0;
			written_q   <= '0;
			act_q       <= '0;
			idx_q       <= '0;
			pend_s1     <= 1'b0;
			ev_q        <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				thr_q <= 32'((17'(cfg_data) + 17'd1) * 32'(MS_PER_S));
			end
			if (state_q == ST_DONE && commit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						idx_q   <= '0;
						pend_s1 <= 1'b0;
						ev_q    <= '0;
						state_q <= (cmd_t'(s_axis_tuser) == CMD_SWEEP) ? ST_SWEEP : ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					state_q <= ST_DONE;
				end
				ST_SWEEP: begin
					if (pend_s1 && valid_q[pidx_s1] && sweep_exp) begin
						valid_q[pidx_s1] <= 1'b0;
						act_q            <= act_q - CNT_W'(1);
						ev_q             <= ev_q + 5'd1;
					end
					if (idx_q < CNT_W'(TABLE_SLOTS)) begin
						idx_q   <= idx_q + CNT_W'(1);
						pend_s1 <= 1'b1;
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (commit) begin
						state_q <= ST_IDLE;
						if (rec_we) begin
							valid_q[slot_q]   <= 1'b1;
							written_q[slot_q] <= 1'b1;
						end
						if (ins) begin
							act_q <= act_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The active counter tracks the valid bits.
	a_active_count: assert property (@(posedge clk) disable iff (!arst_n)
		act_q == CNT_W'($countones(valid_q)))
		else $error("active count differs from valid bits");

	// Record writes come only from a committing update.
	a_rec_write: assert property (@(posedge clk) disable iff (!arst_n)
		rec_we |-> (state_q == ST_DONE && cmd_q == CMD_UPDATE))
		else $error("record write outside an update");

	// The record memory is never read and written in the same cycle.
	a_rec_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(rec_we && rec_re))
		else $error("record read overlaps a write");

	// A result is loaded only while the sequencer leaves its result state.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE && state_q == ST_IDLE)
		else $error("result loaded outside the result state");

endmodule

`default_nettype wire
